// File: design/csle_pkg.sv
package csle_pkg;

   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_QMARK    = 8'h3F;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TILDE    = 8'h7E;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_T        = 8'h74;
   localparam logic [7:0] CHAR_X        = 8'h78;
   localparam logic [7:0] OCTAL_ONE_MAX = 8'h07;

   localparam logic [7:0] LINE_LIMIT_RESET  = 8'd100;
   localparam logic [7:0] LINE_LENGTH_RESET = 8'd1;

   // Register index on the configuration port
   localparam logic REG_LINE_LIMIT = 1'b0;

   // One classified byte: its escape text plus the prefixes to emit first
   typedef struct packed {
      logic [3:0][7:0] text;
      logic [2:0]      text_len;
      logic            line_break;
      logic            quote_break;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: design/csle_stream_if.sv
interface csle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_of_stream;

   modport source (output valid, output in_byte, output start_of_stream, input ready);
   modport sink (input valid, input in_byte, input start_of_stream, output ready);
endinterface

interface csle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// File: design/c_string_literal_escaper_core.sv
// A byte accepted on req_chan is written into the job queue; the back end then moves
//    its characters through its single output register onto rsp_chan, one per cycle
//    while rsp_chan is ready. A byte yields 1 to 7 characters; that register sets the rate.
// The front end accepts a new byte every cycle while the job queue has room.
// Reset (synchronous, active high): empty the queue, line length 1, numeric-escape
//    flag clear, line_limit 100.
module c_string_literal_escaper_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   csle_req_if.sink    req_chan,
   csle_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import csle_pkg::*;

   logic [7:0]   line_limit_ff, line_limit_in;
   logic         csr_write;
   logic         reg_sel;

   logic         push_valid;
   job_type      push_job;
   job_type      head_job;
   logic         pop;
   q_status_type q_status;

   // Configuration port: zero-wait APB, one register at index 0
   assign pready    = 1'b1;
   assign reg_sel   = (paddr[2] == REG_LINE_LIMIT);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      line_limit_in = line_limit_ff;
      if (csr_write && reg_sel) begin
         line_limit_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= LINE_LIMIT_RESET;
      end else begin
         line_limit_ff <= line_limit_in;
      end
   end

   // Read back the limit; addresses past the register list read zero
   assign prdata = reg_sel ? {24'b0, line_limit_ff} : 32'b0;

   // Front: accept, classify, track line length, push a job per transaction
   csle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .line_limit (line_limit_ff),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Decouple classification from character output
   csle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // Back: walk each job one character per cycle, while rsp_chan is not stalled, into the output register
   csle_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: design/csle_front.sv
module csle_front (
   input  logic                  clock,
   input  logic                  reset,
   csle_req_if.sink              req_chan,
   input  logic [7:0]            line_limit,
   input  csle_pkg::q_status_type q_status,
   output logic                  push_valid,
   output csle_pkg::job_type     push_job
);
   import csle_pkg::*;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'b0, d};
      end else begin
         r = 8'h41 + {4'b0, d} - 8'd10;
      end
      return r;
   endfunction

   function automatic logic is_hex_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   logic [7:0] line_length_ff, line_length_in;
   logic       after_num_ff, after_num_in;

   logic [7:0] b;
   logic [7:0] len_eff;
   logic       after_eff;
   logic       numeric;
   logic       qbreak;
   logic       lbreak;
   logic [8:0] sum;
   logic [3:0][7:0] text;
   logic [2:0] text_len;
   logic       accept;

   assign req_chan.ready = !q_status.full;
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.in_byte;

   // Classify the byte into its escape text and work out the line and quote breaks
   always_comb begin
      len_eff   = req_chan.start_of_stream ? LINE_LENGTH_RESET : line_length_ff;
      after_eff = req_chan.start_of_stream ? 1'b0 : after_num_ff;
      text      = '0;
      numeric   = 1'b0;
      qbreak    = 1'b0;
      if (b == CHAR_BSLASH || b == CHAR_TAB || b == CHAR_QMARK) begin
         text[0]  = CHAR_BSLASH;
         text[1]  = (b == CHAR_TAB) ? CHAR_T : b;
         text_len = 3'd2;
      end else if (b < CHAR_SPACE || b == CHAR_QUOTE) begin
         text[0] = CHAR_BSLASH;
         numeric = 1'b1;
         if (b <= OCTAL_ONE_MAX) begin
            text[1]  = CHAR_ZERO + {5'b0, b[2:0]};
            text_len = 3'd2;
         end else begin
            text[1]  = CHAR_ZERO + {5'b0, b[5:3]};
            text[2]  = CHAR_ZERO + {5'b0, b[2:0]};
            text_len = 3'd3;
         end
      end else if (b > CHAR_TILDE) begin
         text[0]  = CHAR_BSLASH;
         text[1]  = CHAR_X;
         text[2]  = hex_char(b[7:4]);
         text[3]  = hex_char(b[3:0]);
         text_len = 3'd4;
         numeric  = 1'b1;
      end else begin
         text[0]  = b;
         text_len = 3'd1;
         qbreak   = after_eff && is_hex_char(b);
      end

      sum    = {1'b0, len_eff} + {6'b0, text_len} + (qbreak ? 9'd2 : 9'd0);
      lbreak = (sum >= {1'b0, line_limit});
      if (lbreak) begin
         qbreak = 1'b0;
         sum    = 9'd1 + {6'b0, text_len};
      end
      line_length_in = accept ? sum[7:0] : line_length_ff;
      after_num_in   = accept ? numeric : after_num_ff;
   end

   assign push_valid           = accept;
   assign push_job.text        = text;
   assign push_job.text_len    = text_len;
   assign push_job.line_break  = lbreak;
   assign push_job.quote_break = qbreak;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         after_num_ff   <= 1'b0;
      end else begin
         line_length_ff <= line_length_in;
         after_num_ff   <= after_num_in;
      end
   end

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_length_ff != 8'd0)
      else $error("line length dropped to zero");

endmodule

// File: design/csle_queue.sv
module csle_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  csle_pkg::job_type      push_job,
   input  logic                   pop,
   output csle_pkg::job_type      head_job,
   output csle_pkg::q_status_type q_status
);
   import csle_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_status.full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

// File: design/csle_back.sv
module csle_back (
   input  logic                   clock,
   input  logic                   reset,
   input  csle_pkg::job_type      head_job,
   input  csle_pkg::q_status_type q_status,
   output logic                   pop,
   csle_rsp_if.source             rsp_chan
);
   import csle_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;

   logic [2:0] pre_len;
   logic [2:0] total_len;
   logic [2:0] text_idx;
   logic [7:0] cur_char;
   logic       cur_last;
   logic       out_free;
   logic       emit;

   // Sequence: optional quote-newline-quote, optional "", then the text
   always_comb begin
      pre_len   = head_job.line_break ? 3'd3 : (head_job.quote_break ? 3'd2 : 3'd0);
      total_len = pre_len + head_job.text_len;
      text_idx  = idx_ff - pre_len;
      if (idx_ff < pre_len) begin
         cur_char = (head_job.line_break && idx_ff == 3'd1) ? CHAR_NEWLINE : CHAR_QUOTE;
      end else begin
         cur_char = head_job.text[text_idx[1:0]];
      end
      cur_last = (idx_ff == total_len - 3'd1);
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = out_free && !q_status.empty;
   assign pop      = emit && cur_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (emit) begin
         idx_in       = cur_last ? 3'd0 : idx_ff + 3'd1;
         rsp_char_in  = cur_char;
         rsp_last_in  = cur_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (idx_ff < total_len))
      else $error("character index past end of transaction text");

endmodule

// File: sim/c_string_literal_escaper_core_tb.sv
`timescale 1ns / 1ps

module c_string_literal_escaper_core_tb;
   import csle_pkg::*;

   // Register map: register i sits at byte address 4*i.
   localparam logic [2:0] CSR_LINE_LIMIT_ADDR = {REG_LINE_LIMIT, 2'b00};
   localparam logic [2:0] CSR_UNMAPPED_ADDR   = 3'd4;

   // Give up after this many cycles with no transaction on either channel.
   localparam int QUIET_LIMIT  = 2000;
   // Flush margin at the end of the run.
   localparam int FLUSH_CYCLES = 10;
   localparam int RANDOM_ITEMS_PER_PHASE = 8;

   // One expected character of escaped text
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } esc_char_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   csle_req_if req_bus ();
   csle_rsp_if rsp_bus ();

   c_string_literal_escaper_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Escaper state as the testbench sees it
   logic [7:0] line_limit_q  = LINE_LIMIT_RESET;
   logic [7:0] line_len_q    = LINE_LENGTH_RESET;
   logic       after_num_q   = 1'b0;

   esc_char_type pending_chars[$];
   esc_char_type expected_char;
   int         error_count   = 0;
   int         quiet_cycles  = 0;
   int         send_idle_pct = 24;
   int         recv_idle_pct = 84;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return (nib < 4'd10) ? CHAR_ZERO + nib : "A" + nib - 8'd10;
   endfunction

   function automatic bit is_hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic void push_char(input logic [7:0] c, input logic last);
      esc_char_type ent;
      ent.ch   = c;
      ent.last = last;
      pending_chars.push_back(ent);
   endfunction

   // Work out the escaped text for one raw byte and queue its characters.
   function automatic void escape_byte(input logic [7:0] b, input logic sos);
      logic [7:0] text [4];
      int         tlen;
      int         sum;
      bit         numeric;
      bit         quote_break;
      numeric     = 1'b0;
      quote_break = 1'b0;
      if (sos) begin
         line_len_q  = LINE_LENGTH_RESET;
         after_num_q = 1'b0;
      end
      if (b == CHAR_BSLASH || b == CHAR_TAB || b == CHAR_QMARK) begin
         text[0] = CHAR_BSLASH;
         text[1] = (b == CHAR_TAB) ? CHAR_T : b;
         tlen    = 2;
      end else if (b < CHAR_SPACE || b == CHAR_QUOTE) begin
         text[0] = CHAR_BSLASH;
         if (b <= OCTAL_ONE_MAX) begin
            text[1] = CHAR_ZERO + b;
            tlen    = 2;
         end else begin
            text[1] = CHAR_ZERO + {5'd0, b[5:3]};
            text[2] = CHAR_ZERO + {5'd0, b[2:0]};
            tlen    = 3;
         end
         numeric = 1'b1;
      end else if (b > CHAR_TILDE) begin
         text[0] = CHAR_BSLASH;
         text[1] = CHAR_X;
         text[2] = hex_digit(b[7:4]);
         text[3] = hex_digit(b[3:0]);
         tlen    = 4;
         numeric = 1'b1;
      end else begin
         text[0]     = b;
         tlen        = 1;
         quote_break = after_num_q && is_hex_char(b);
      end
      // The sum does not wrap: a limit at or below it always breaks.
      sum = int'(line_len_q) + tlen + (quote_break ? 2 : 0);
      if (sum >= int'(line_limit_q)) begin
         push_char(CHAR_QUOTE, 1'b0);
         push_char(CHAR_NEWLINE, 1'b0);
         push_char(CHAR_QUOTE, 1'b0);
         // The line break already separates a following hex digit.
         quote_break = 1'b0;
         sum         = 1 + tlen;
      end
      line_len_q = sum[7:0];
      if (quote_break) begin
         push_char(CHAR_QUOTE, 1'b0);
         push_char(CHAR_QUOTE, 1'b0);
      end
      for (int i = 0; i < tlen; i++) begin
         push_char(text[i], i == tlen - 1);
      end
      after_num_q = numeric;
   endfunction

   // Predict on every accepted input transaction.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         escape_byte(req_bus.in_byte, req_bus.start_of_stream);
      end
   end

   // Compare every accepted character with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                      rsp_bus.out_char, rsp_bus.last_char));
         end else begin
            expected_char = pending_chars.pop_front();
            if (rsp_bus.out_char !== expected_char.ch) begin
               report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                         rsp_bus.out_char, expected_char.ch));
            end
            if (rsp_bus.last_char !== expected_char.last) begin
               report_mismatch($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                         rsp_bus.last_char, expected_char.last,
                                         expected_char.ch));
            end
         end
      end
   end

   // Stall the result channel at random; the rate follows the current phase.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Idle the sender cycle by cycle at the current rate, then offer one byte
   // and hold it until the block takes it. Valid stays high afterwards so
   // the next byte can follow back to back.
   task automatic send_byte(input logic [7:0] b, input logic sos);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.in_byte         <= b;
      req_bus.start_of_stream <= sos;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and hold off until every expected character has come.
   task automatic wait_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // Writes beyond the register list are dropped.
      if ((addr >> 2) == REG_LINE_LIMIT) begin
         line_limit_q = data[7:0];
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_check_limit();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_LINE_LIMIT_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(line_limit_q)) begin
         report_mismatch($sformatf("line_limit reads 0x%08h, expected 0x%08h",
                                   prdata, 32'(line_limit_q)));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Weighted pick over the byte classes, heavy on hex digits so that the
   // empty-string break after numeric escapes comes up often.
   function automatic logic [7:0] pick_raw_byte();
      int sel;
      int k;
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, 21);
      if (sel < 20) begin
         return 8'($urandom_range(0, 31));
      end else if (sel < 35) begin
         return 8'($urandom_range(127, 255));
      end else if (sel < 45) begin
         case (k % 4)
            0:       return CHAR_BSLASH;
            1:       return CHAR_TAB;
            2:       return CHAR_QMARK;
            default: return CHAR_QUOTE;
         endcase
      end else if (sel < 75) begin
         if (k < 10) return CHAR_ZERO + 8'(k);
         else if (k < 16) return "a" + 8'(k - 10);
         else return "A" + 8'(k - 16);
      end else begin
         return 8'($urandom_range(32, 126));
      end
   endfunction

   // Every escape class at least once, plus hex digits right after each kind of escape.
   task automatic test_escape_classes();
      send_byte(8'h00, 1'b1);      // shortest octal escape
      send_byte(OCTAL_ONE_MAX, 1'b0);
      send_byte(8'h08, 1'b0);      // first two-digit octal
      send_byte(8'h1F, 1'b0);
      send_byte(CHAR_TAB, 1'b0);
      send_byte(CHAR_BSLASH, 1'b0);
      send_byte(CHAR_QMARK, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte("0", 1'b0);        // hex digit after hex escape
      send_byte(8'h01, 1'b0);
      send_byte("A", 1'b0);        // hex digit after octal escape
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte("f", 1'b0);
      send_byte(8'h1B, 1'b0);
      send_byte("g", 1'b0);        // not a hex digit: no break
      send_byte(CHAR_BSLASH, 1'b0);
      send_byte("a", 1'b0);        // after a two-char escape: no break
      send_byte(8'h02, 1'b0);
      send_byte("F", 1'b1);        // start of stream clears the flag
      send_byte("z", 1'b0);
      wait_drain();
   endtask

   task automatic test_line_limits();
      csr_check_limit();
      // Write beyond the register list, then confirm nothing moved.
      csr_write(CSR_UNMAPPED_ADDR, 32'hFFFF_FF09);
      csr_check_limit();

      // Low limit: breaks land on numeric escapes and on hex digits
      // that would otherwise need the empty-string break.
      csr_write(CSR_LINE_LIMIT_ADDR, 32'h0000_0008);
      csr_check_limit();
      send_byte(8'h01, 1'b1);
      send_byte("A", 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte("B", 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte("D", 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte("5", 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte("e", 1'b0);        // break drops the empty-string break
      wait_drain();

      // Zero and one are below any sum: break before every byte.
      csr_write(CSR_LINE_LIMIT_ADDR, 32'h0000_0000);
      send_byte("x", 1'b0);
      send_byte(8'hC4, 1'b0);
      send_byte("c", 1'b0);
      wait_drain();
      csr_write(CSR_LINE_LIMIT_ADDR, 32'h0000_0001);
      send_byte(8'h10, 1'b1);
      send_byte("q", 1'b0);
      wait_drain();

      // All ones, with noise above the register width.
      csr_write(CSR_LINE_LIMIT_ADDR, 32'hA5A5_A5FF);
      csr_check_limit();
      send_byte(8'hFE, 1'b1);
      send_byte("9", 1'b0);
      wait_drain();

      // Near the top of the range: long hex run so the line fills once.
      csr_write(CSR_LINE_LIMIT_ADDR, 32'd250);
      send_byte(8'($urandom_range(128, 255)), 1'b1);
      repeat (63) send_byte(8'($urandom_range(128, 255)), 1'b0);
      wait_drain();

      // Lower the limit mid-line: the next byte breaks at once.
      csr_write(CSR_LINE_LIMIT_ADDR, 32'd8);
      send_byte("7", 1'b0);
      send_byte("p", 1'b0);
      wait_drain();
   endtask

   // Three phases: sender mostly busy, receiver mostly busy, then no idling.
   task automatic test_random_stream();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 84 : 0;
         recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 24 : 0;
         wait_drain();
         case (phase)
            0:       csr_write(CSR_LINE_LIMIT_ADDR, {24'($urandom_range(0, 32'hFF_FFFF)),
                                                     8'($urandom_range(8, 40))});
            1:       csr_write(CSR_LINE_LIMIT_ADDR, 32'($urandom_range(41, 250)));
            default: csr_write(CSR_LINE_LIMIT_ADDR, 32'($urandom_range(0, 255)));
         endcase
         for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
            // Hold the sender once until every expected char is out.
            if (phase == 1 && i == RANDOM_ITEMS_PER_PHASE / 2) wait_drain();
            send_byte(pick_raw_byte(), $urandom_range(0, 7) == 0);
         end
      end
      wait_drain();
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.in_byte         = 8'h00;
      req_bus.start_of_stream = 1'b0;
      rsp_bus.ready           = 1'b0;
      psel                    = 1'b0;
      penable                 = 1'b0;
      pwrite                  = 1'b0;
      paddr                   = '0;
      pwdata                  = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_escape_classes();
      test_line_limits();
      test_random_stream();

      // Wait out the flush margin to catch stray characters.
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/csle_pkg.sv
design/csle_stream_if.sv
design/csle_front.sv
design/csle_queue.sv
design/csle_back.sv
design/c_string_literal_escaper_core.sv
sim/c_string_literal_escaper_core_tb.sv
